>>> rtl/mmsf_pkg.sv
// Shared types and constants for the Modbus motor speed framer.
// Used by the front, queue and back modules and by the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmsf_pkg;

    // Command modes carried in the input tuser field
    localparam logic [2:0] MODE_SET_ALL  = 3'd0;
    localparam logic [2:0] MODE_SET_ONE  = 3'd1;
    localparam logic [2:0] MODE_STOP_ALL = 3'd2;
    localparam logic [2:0] MODE_WR_SINGLE = 3'd3;
    localparam logic [2:0] MODE_READBACK = 3'd4;

    // Modbus framing constants
    localparam logic [7:0]  SLAVE_RESET     = 8'h0A;
    localparam logic [7:0]  FN_WRITE_MULTI  = 8'h10;
    localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  REG_COUNT       = 8'h04;
    localparam logic [7:0]  DATA_BYTES      = 8'h08;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    localparam int NUM_MOTORS = 4;
    localparam int Q_DEPTH    = 2;

    // Byte position counter; a multiple-register frame is 17 bytes long
    localparam int POS_W = 5;

    // APB register map
    localparam int          APB_AW       = 3;
    localparam logic        REG_IDX_SLAVE = 1'b0;

    typedef enum logic [1:0] {
        OP_MULTI,
        OP_SINGLE,
        OP_READ
    } t_op;

    // Work item handed from the front to the back. For OP_MULTI data holds
    // the four speeds, for OP_SINGLE data[0] holds the register address,
    // for OP_READ data[0] holds the readback value.
    typedef struct packed {
        t_op                         op;
        logic [NUM_MOTORS-1:0][15:0] data;
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/mmsf_front.sv
// Front end: accepts command items, keeps the speed cache and classifies
// each item into a work item for the frame queue. Depends on mmsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmsf_front
    import mmsf_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [103:0] i_s_tdata,  // speed_first, speed_second, speed_third,
                                          // speed_fourth, one_speed, motor_index,
                                          // register_address
    input  wire logic [2:0]   i_s_tuser,  // mode
    input  wire logic         i_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [NUM_MOTORS-1:0][15:0] r_cache;
    logic [NUM_MOTORS-1:0][15:0] n_cache;
    logic [NUM_MOTORS-1:0][15:0] in_speeds;
    logic [15:0] one_speed;
    logic [7:0]  motor_index;
    logic [15:0] register_address;
    logic        idx_ok;
    logic        accept;

    assign in_speeds[0]     = i_s_tdata[15:0];
    assign in_speeds[1]     = i_s_tdata[31:16];
    assign in_speeds[2]     = i_s_tdata[47:32];
    assign in_speeds[3]     = i_s_tdata[63:48];
    assign one_speed        = i_s_tdata[79:64];
    assign motor_index      = i_s_tdata[87:80];
    assign register_address = i_s_tdata[103:88];

    assign idx_ok     = (motor_index < 8'(NUM_MOTORS));
    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_cache = r_cache;
        o_push  = 1'b0;
        o_cmd.op   = OP_MULTI;
        o_cmd.data = '0;
        unique case (i_s_tuser)
            MODE_SET_ALL: begin
                n_cache = in_speeds;
                o_push  = accept;
            end
            MODE_SET_ONE: begin
                if (idx_ok) begin
                    n_cache[motor_index[1:0]] = one_speed;
                    o_push = accept;
                end
            end
            MODE_STOP_ALL: begin
                n_cache = '0;
                o_push  = accept;
            end
            MODE_WR_SINGLE: begin
                o_cmd.op = OP_SINGLE;
                o_push   = accept;
            end
            MODE_READBACK: begin
                o_cmd.op = OP_READ;
                o_push   = accept;
            end
            default: begin
                // Unused modes are consumed without any effect.
            end
        endcase

        if (o_cmd.op == OP_MULTI) begin
            o_cmd.data = n_cache;
        end else if (o_cmd.op == OP_SINGLE) begin
            o_cmd.data[0] = register_address;
        end else begin
            o_cmd.data[0] = idx_ok ? r_cache[motor_index[1:0]] : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache <= '0;
        end else if (accept) begin
            r_cache <= n_cache;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mmsf_queue.sv
// Short FIFO of work items between the front and the back end.
// Depends on mmsf_pkg for the work item type.
`timescale 1ns / 1ps
`default_nettype none

module mmsf_queue
    import mmsf_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/mmsf_back.sv
// Back end: walks the work item at the queue head byte by byte, runs the
// Modbus CRC-16 and drives the registered output stream. Depends on mmsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmsf_back
    import mmsf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [7:0]  i_slave,
    input  wire logic        i_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_pop,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,  // frame_byte, readback_speed
    output logic             o_m_tuser,  // kind
    output logic             o_m_tlast   // last
);

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_crc;
    logic             r_ovalid;
    logic             r_kind;
    logic [7:0]       r_byte;
    logic [15:0]      r_rb;
    logic             r_last;

    logic             slot_free;
    logic             emit;
    logic [7:0]       cur_byte;
    logic             cur_is_crc;
    logic             cur_last;
    logic [15:0]      rb_val;
    logic             cur_kind;

    assign slot_free = !r_ovalid || i_m_tready;
    assign emit      = i_valid && slot_free;
    assign o_pop     = emit && cur_last;

    always_comb begin
        cur_byte   = 8'h00;
        cur_is_crc = 1'b0;
        cur_last   = 1'b0;
        rb_val     = 16'd0;
        cur_kind   = 1'b0;
        unique case (i_cmd.op)
            OP_MULTI: begin
                case (r_pos)
                    5'd0:  cur_byte = i_slave;
                    5'd1:  cur_byte = FN_WRITE_MULTI;
                    5'd5:  cur_byte = REG_COUNT;
                    5'd6:  cur_byte = DATA_BYTES;
                    5'd7:  cur_byte = i_cmd.data[0][15:8];
                    5'd8:  cur_byte = i_cmd.data[0][7:0];
                    5'd9:  cur_byte = i_cmd.data[1][15:8];
                    5'd10: cur_byte = i_cmd.data[1][7:0];
                    5'd11: cur_byte = i_cmd.data[2][15:8];
                    5'd12: cur_byte = i_cmd.data[2][7:0];
                    5'd13: cur_byte = i_cmd.data[3][15:8];
                    5'd14: cur_byte = i_cmd.data[3][7:0];
                    5'd15: cur_byte = r_crc[7:0];
                    5'd16: cur_byte = r_crc[15:8];
                    default: cur_byte = 8'h00;
                endcase
                cur_is_crc = (r_pos >= 5'd15);
                cur_last   = (r_pos == 5'd16);
            end
            OP_SINGLE: begin
                case (r_pos)
                    5'd0:  cur_byte = i_slave;
                    5'd1:  cur_byte = FN_WRITE_SINGLE;
                    5'd2:  cur_byte = i_cmd.data[0][15:8];
                    5'd3:  cur_byte = i_cmd.data[0][7:0];
                    5'd5:  cur_byte = 8'h01;
                    5'd6:  cur_byte = r_crc[7:0];
                    5'd7:  cur_byte = r_crc[15:8];
                    default: cur_byte = 8'h00;
                endcase
                cur_is_crc = (r_pos >= 5'd6);
                cur_last   = (r_pos == 5'd7);
            end
            OP_READ: begin
                cur_kind = 1'b1;
                rb_val   = i_cmd.data[0];
                cur_last = 1'b1;
            end
            default: begin
                // Never queued; drop it so the queue cannot lock up.
                cur_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= CRC_INIT;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
                if (cur_last) begin
                    r_pos <= '0;
                    r_crc <= CRC_INIT;
                end else begin
                    r_pos <= r_pos + 1'b1;
                    if (!cur_is_crc) begin
                        r_crc <= crc_byte(r_crc, cur_byte);
                    end
                end
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= cur_kind;
            r_byte <= cur_byte;
            r_rb   <= rb_val;
            r_last <= cur_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_rb, r_byte};
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

endmodule

`default_nettype wire

>>> rtl/modbus_motor_speed_framer_top.sv
// Top level of the Modbus motor speed framer: APB slave address register,
// front end, work item queue and byte-serial back end. Depends on mmsf_pkg.
//
//  Channel  Direction  Handshake              Payload
//  s        in         i_s_tvalid/o_s_tready  tdata: speeds, index, register; tuser: mode
//  m        out        o_m_tvalid/i_m_tready  tdata: frame_byte, readback_speed; tuser: kind; tlast
//  apb      in         psel/penable/pwrite    pwdata[7:0]: slave_address at address 0
//
// A command is taken whenever the two-entry queue has room.
// The back end emits one frame byte per cycle while the output does not
// stall: 17 bytes for a multiple register frame, 8 for a single register
// write, one item for a readback; the CRC is updated one byte at a time.
// Synchronous reset clears the cache to zero, the slave address to 10 and the queue.
// Stalls on the output hold the current byte and let the front fill the queue.
`timescale 1ns / 1ps
`default_nettype none

module modbus_motor_speed_framer_top
    import mmsf_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [103:0]      i_s_tdata,  // speed_first, speed_second, speed_third,
                                               // speed_fourth, one_speed, motor_index,
                                               // register_address
    input  wire logic [2:0]        i_s_tuser,  // mode
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [23:0]            o_m_tdata,  // frame_byte, readback_speed
    output logic                   o_m_tuser,  // kind
    output logic                   o_m_tlast,  // last
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [7:0] r_slave;
    logic       cfg_wr;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    t_cmd       front_cmd;
    t_cmd       head_cmd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_IDX_SLAVE) ? {24'd0, r_slave} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave <= SLAVE_RESET;
        end else if (cfg_wr && paddr[2] == REG_IDX_SLAVE) begin
            r_slave <= pwdata[7:0];
        end
    end

    mmsf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    mmsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    mmsf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_slave    (r_slave),
        .i_valid    (q_valid),
        .i_cmd      (head_cmd),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for modbus_motor_speed_framer_top.
// Drives commands and APB writes, predicts every frame byte and readback and compares them.
// Depends on mmsf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module tb_top
    import mmsf_pkg::*;
;

    localparam logic [2:0]        MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0]        MODE_SPARE_LAST  = 3'd7;
    localparam logic [APB_AW-1:0] APB_SLAVE_ADDR   = '0;
    localparam int                SETTLE_CYCLES    = 40;
    localparam int                ITEMS_PER_PHASE  = 22;

    // Input payload, first field in the highest bits so it maps onto tdata directly.
    typedef struct packed {
        logic [15:0] reg_addr;
        logic [7:0]  motor_idx;
        logic [15:0] one_speed;
        logic [15:0] spd3;
        logic [15:0] spd2;
        logic [15:0] spd1;
        logic [15:0] spd0;
    } t_speed_cmd;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_byte;
        logic [15:0] speed;
        logic        last;
    } t_out_item;

    class frame_scoreboard;
        logic [7:0]  slave_addr;
        logic [15:0] speed_cache[4];
        t_out_item   pending_outputs[$];
        int          n_errors;
        int          n_commands;
        int          n_checked;

        function new();
            slave_addr = SLAVE_RESET;
            foreach (speed_cache[k]) speed_cache[k] = 16'h0000;
            n_errors   = 0;
            n_commands = 0;
            n_checked  = 0;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        // Bitwise Modbus CRC-16, reflected polynomial, seeded with all ones.
        function logic [15:0] modbus_crc(input logic [7:0] msg[$]);
            logic [15:0] crc;
            crc = CRC_INIT;
            foreach (msg[i]) begin
                crc = crc ^ {8'h00, msg[i]};
                for (int b = 0; b < 8; b++) begin
                    if (crc[0]) begin
                        crc = (crc >> 1) ^ CRC_POLY;
                    end else begin
                        crc = crc >> 1;
                    end
                end
            end
            return crc;
        endfunction

        function void push_frame(input logic [7:0] msg[$]);
            logic [15:0] crc;
            crc = modbus_crc(msg);
            msg.push_back(crc[7:0]);
            msg.push_back(crc[15:8]);
            foreach (msg[i]) begin
                pending_outputs.push_back('{kind: 1'b0, frame_byte: msg[i], speed: 16'h0000,
                                            last: (i == msg.size() - 1)});
            end
        endfunction

        function void push_speed_frame();
            logic [7:0] msg[$];
            msg.push_back(slave_addr);
            msg.push_back(FN_WRITE_MULTI);
            msg.push_back(8'h00);
            msg.push_back(8'h00);
            msg.push_back(8'h00);
            msg.push_back(REG_COUNT);
            msg.push_back(DATA_BYTES);
            foreach (speed_cache[k]) begin
                msg.push_back(speed_cache[k][15:8]);
                msg.push_back(speed_cache[k][7:0]);
            end
            push_frame(msg);
        endfunction

        function void note_command(input logic [2:0] mode, input t_speed_cmd cmd);
            logic [7:0] msg[$];
            n_commands++;
            case (mode)
                MODE_SET_ALL: begin
                    speed_cache[0] = cmd.spd0;
                    speed_cache[1] = cmd.spd1;
                    speed_cache[2] = cmd.spd2;
                    speed_cache[3] = cmd.spd3;
                    push_speed_frame();
                end
                MODE_SET_ONE: begin
                    // An out-of-range motor leaves the cache alone and sends nothing.
                    if (cmd.motor_idx < NUM_MOTORS) begin
                        speed_cache[cmd.motor_idx[1:0]] = cmd.one_speed;
                        push_speed_frame();
                    end
                end
                MODE_STOP_ALL: begin
                    foreach (speed_cache[k]) speed_cache[k] = 16'h0000;
                    push_speed_frame();
                end
                MODE_WR_SINGLE: begin
                    msg.push_back(slave_addr);
                    msg.push_back(FN_WRITE_SINGLE);
                    msg.push_back(cmd.reg_addr[15:8]);
                    msg.push_back(cmd.reg_addr[7:0]);
                    msg.push_back(8'h00);
                    msg.push_back(8'h01);
                    push_frame(msg);
                end
                MODE_READBACK: begin
                    pending_outputs.push_back('{kind: 1'b1, frame_byte: 8'h00,
                        speed: (cmd.motor_idx < NUM_MOTORS) ?
                               speed_cache[cmd.motor_idx[1:0]] : 16'h0000,
                        last: 1'b1});
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(input string what);
            n_errors++;
            if (n_errors <= 30) $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task check_output(input t_out_item got);
            t_out_item want;
            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected item kind=%0b byte=%02h speed=%04h last=%0b",
                                          got.kind, got.frame_byte, got.speed, got.last));
                return;
            end
            want = pending_outputs.pop_front();
            n_checked++;
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0b, expected %0b", got.kind, want.kind));
            if (got.frame_byte !== want.frame_byte)
                report_mismatch($sformatf("frame byte %02h, expected %02h",
                                          got.frame_byte, want.frame_byte));
            if (got.speed !== want.speed)
                report_mismatch($sformatf("readback speed %04h, expected %04h",
                                          got.speed, want.speed));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
        endtask
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [103:0]      i_s_tdata  = '0;  // speed_first, speed_second, speed_third,
                                         // speed_fourth, one_speed, motor_index,
                                         // register_address
    logic [2:0]        i_s_tuser  = '0;  // mode
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [23:0]       o_m_tdata;        // frame_byte, readback_speed
    logic              o_m_tuser;        // kind
    logic              o_m_tlast;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [APB_AW-1:0] paddr      = '0;
    logic [31:0]       pwdata     = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic              no_idle    = 1'b0;
    frame_scoreboard   frames_sb;

    always #5 i_clk = ~i_clk;

    modbus_motor_speed_framer_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            frames_sb.check_output('{kind: o_m_tuser, frame_byte: o_m_tdata[7:0],
                                     speed: o_m_tdata[23:8], last: o_m_tlast});
        end
    end

    // Output side: a random stall before each item, none during burst phases.
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(9, 0);
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    function automatic t_speed_cmd rand_cmd();
        t_speed_cmd c;
        c.reg_addr  = 16'($urandom);
        c.motor_idx = 8'($urandom);
        c.one_speed = 16'($urandom);
        c.spd3      = 16'($urandom);
        c.spd2      = 16'($urandom);
        c.spd1      = 16'($urandom);
        c.spd0      = 16'($urandom);
        return c;
    endfunction

    // Valid stays high across back-to-back items; it drops only ahead of a gap.
    task automatic send_cmd(input logic [2:0] mode, input t_speed_cmd cmd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(9, 0);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= cmd;
        i_s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        frames_sb.note_command(mode, cmd);
    endtask

    task automatic send_indexed(input logic [2:0] mode, input logic [7:0] idx,
                                input logic [15:0] speed);
        t_speed_cmd c;
        c           = rand_cmd();
        c.motor_idx = idx;
        c.one_speed = speed;
        send_cmd(mode, c);
    endtask

    task automatic send_random();
        t_speed_cmd c;
        int         pick;
        logic [2:0] mode;
        c    = rand_cmd();
        pick = $urandom_range(99, 0);
        if (pick < 25)      mode = MODE_SET_ALL;
        else if (pick < 50) mode = MODE_SET_ONE;
        else if (pick < 60) mode = MODE_STOP_ALL;
        else if (pick < 75) mode = MODE_WR_SINGLE;
        else if (pick < 95) mode = MODE_READBACK;
        else                mode = 3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
        // Mostly valid motor numbers so set-one and readback do real work.
        if ($urandom_range(99, 0) < 85) c.motor_idx = 8'($urandom_range(NUM_MOTORS - 1, 0));
        else                            c.motor_idx = 8'($urandom_range(255, NUM_MOTORS));
        send_cmd(mode, c);
    endtask

    task automatic drop_valid();
        i_s_tvalid <= 1'b0;
    endtask

    // Wait for every expected item, then let any command without output drain.
    task automatic settle();
        while (frames_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write_slave(input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_SLAVE_ADDR;
        pwdata  <= {24'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frames_sb.slave_addr = value;
    endtask

    initial begin
        t_speed_cmd c;
        logic [7:0] addr_plan[4];
        frames_sb = new();
        addr_plan = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands with the reset slave address.
        c      = rand_cmd();
        c.spd0 = 16'h7FFF;
        c.spd1 = 16'h8000;
        c.spd2 = 16'hFFFF;
        c.spd3 = 16'h0000;
        send_cmd(MODE_SET_ALL, c);
        for (int k = 0; k < NUM_MOTORS; k++) send_indexed(MODE_READBACK, 8'(k), 16'($urandom));
        send_indexed(MODE_READBACK, 8'd4, 16'($urandom));
        send_indexed(MODE_READBACK, 8'd255, 16'($urandom));
        send_indexed(MODE_SET_ONE, 8'd2, 16'hFFFF);
        send_indexed(MODE_SET_ONE, 8'd4, 16'h1234);
        send_indexed(MODE_SET_ONE, 8'd255, 16'h5678);
        send_indexed(MODE_READBACK, 8'd2, 16'($urandom));
        send_cmd(MODE_STOP_ALL, rand_cmd());
        send_indexed(MODE_READBACK, 8'd1, 16'($urandom));
        c          = rand_cmd();
        c.reg_addr = 16'h0000;
        send_cmd(MODE_WR_SINGLE, c);
        c.reg_addr = 16'hFFFF;
        send_cmd(MODE_WR_SINGLE, c);
        c.reg_addr = 16'h1234;
        send_cmd(MODE_WR_SINGLE, c);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) send_cmd(3'(m), rand_cmd());
        send_indexed(MODE_SET_ONE, 8'd0, 16'h8000);
        send_indexed(MODE_SET_ONE, 8'd3, 16'h7FFF);
        drop_valid();
        settle();

        // Random phases, each under its own slave address; the third runs without idling.
        for (int ph = 0; ph < 4; ph++) begin
            apb_write_slave(addr_plan[ph]);
            no_idle = (ph == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
            drop_valid();
            settle();
            no_idle = 1'b0;
        end

        $display("Ran %0d commands and checked %0d output items over five slave addresses,",
                 frames_sb.n_commands, frames_sb.n_checked);
        $display("with extreme speeds, bad motor numbers, spare modes and random stalls.");
        if (frames_sb.n_errors == 0 && frames_sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Run timed out with %0d output items still expected.", frames_sb.pending());
        $display("status: fail");
        $finish;
    end

endmodule
